/* hw/rtl/dtiw_pkg.sv */
// Package with command codes, widths and transaction types for the double to int converter.
package dtiw_pkg;

	localparam int CmdWidth  = 3;
	localparam int DataWidth = 64;

	typedef enum logic [CmdWidth-1:0] {
		CMD_INTEGER = 3'd0,
		CMD_INT32   = 3'd1,
		CMD_UINT32  = 3'd2,
		CMD_UINT16  = 3'd3,
		CMD_BOOLEAN = 3'd4
	} cmd_t;

	typedef struct packed {
		logic [CmdWidth-1:0]  command;
		logic [DataWidth-1:0] number_bits;
	} req_t;

	typedef struct packed {
		logic [DataWidth-1:0] result_bits;
		logic                 truth;
	} rsp_t;

endpackage

/* hw/rtl/dtiw_stream_if.sv */
// Valid/ready stream interface that carries one payload type.
interface dtiw_stream_if #(
	parameter type payload_t = logic
) (
	input logic clk
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

/* hw/rtl/dtiw_convert.sv */
// Combinational conversion of one registered command and double into a result.
module dtiw_convert (
	input  dtiw_pkg::req_t req,
	output dtiw_pkg::rsp_t rsp
);
	logic        sign;
	logic [10:0] expo;
	logic [51:0] frac;
	logic        is_nan, is_inf, is_zero, special;
	logic [52:0] mant;
	logic [84:0] shifted;
	logic [31:0] low, wrapped;
	logic [51:0] keep_mask;
	logic [63:0] trunc;

	// Field decode and class flags.
	assign sign    = req.number_bits[63];
	assign expo    = req.number_bits[62:52];
	assign frac    = req.number_bits[51:0];
	assign is_nan  = (expo == 11'h7FF) && (frac != '0);
	assign is_inf  = (expo == 11'h7FF) && (frac == '0);
	assign is_zero = (req.number_bits[62:0] == '0);
	assign special = is_nan || is_inf || is_zero;
	assign mant    = {1'b1, frac};

	// Integer part modulo 2^32: place the mantissa with its binary point at bit 52.
	always_comb begin
		shifted = '0;
		low     = '0;
		if (expo >= 11'd1023 && expo <= 11'd1023 + 11'd84) begin
			shifted = {32'd0, mant} << (expo - 11'd1023);
			low     = shifted[83:52];
		end
		wrapped = sign ? (32'd0 - low) : low;
	end

	// Truncation toward zero in the double format.
	always_comb begin
		keep_mask = '1;
		if (expo < 11'd1023) begin
			trunc = {sign, 63'd0};
		end else if (expo >= 11'd1075) begin
			trunc = req.number_bits;
		end else begin
			keep_mask = ~(52'hF_FFFF_FFFF_FFFF >> (expo - 11'd1023));
			trunc     = {req.number_bits[63:52], frac & keep_mask};
		end
	end

	// Mode select.
	always_comb begin
		rsp = '0;
		unique case (req.command)
			dtiw_pkg::CMD_INTEGER: begin
				if (is_nan) rsp.result_bits = '0;
				else if (is_inf || is_zero) rsp.result_bits = req.number_bits;
				else rsp.result_bits = trunc;
			end
			dtiw_pkg::CMD_INT32: begin
				if (!special) rsp.result_bits = {{32{wrapped[31]}}, wrapped};
			end
			dtiw_pkg::CMD_UINT32: begin
				if (!special) rsp.result_bits = {32'd0, wrapped};
			end
			dtiw_pkg::CMD_UINT16: begin
				if (!special) rsp.result_bits = {48'd0, wrapped[15:0]};
			end
			dtiw_pkg::CMD_BOOLEAN: begin
				rsp.truth       = !(is_nan || is_zero);
				rsp.result_bits = {63'd0, rsp.truth};
			end
			default: rsp = '0;
		endcase
	end
endmodule

/* hw/rtl/double_to_int_wrap_converter.sv */
// Top level: input register, conversion logic and result register with flow control.
// Converts an IEEE-754 double by command into ToInteger, ToInt32, ToUint32, ToUint16 or
// ToBoolean form. An accepted transaction is registered, converted in one combinational pass,
// and its result is captured in the result register and offered at the output; one
// transaction per cycle is taken while the output is not stalled.
module double_to_int_wrap_converter (
	input logic                 clk,
	input logic                 arst_n,
	dtiw_stream_if.sink         in_if,
	dtiw_stream_if.source       out_if
);
	dtiw_pkg::req_t req_s1;
	dtiw_pkg::rsp_t rsp_c, rsp_s2;
	logic           valid_s1, valid_s2;
	logic           adv_s2, adv_s1;

	// Stages move when the stage ahead is empty or drains.
	assign adv_s2       = !valid_s2 || out_if.ready;
	assign adv_s1       = !valid_s1 || adv_s2;
	assign in_if.ready  = adv_s1;
	assign out_if.valid = valid_s2;
	assign out_if.payload = rsp_s2;

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) valid_s1 <= in_if.valid;
			if (adv_s2) valid_s2 <= valid_s1;
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (adv_s1 && in_if.valid) req_s1 <= in_if.payload;
		if (adv_s2 && valid_s1) rsp_s2 <= rsp_c;
	end

	dtiw_convert u_convert (
		.req (req_s1),
		.rsp (rsp_c)
	);

	// A held result stays put while the sink stalls.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !out_if.ready |=> valid_s2 && $stable(rsp_s2))
		else $error("result changed while stalled");
	// Input is refused only when both stages are full and the output stalls.
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!in_if.ready |-> valid_s1 && valid_s2 && !out_if.ready)
		else $error("input refused without backpressure");
	// An item in the first stage reaches the result register when it can advance.
	a_move: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && adv_s2 |=> valid_s2)
		else $error("item lost between stages");
endmodule
